// ----- rtl/core/pheromone_matrix_update_core_assert.svh -----
// Assertion macros shared by the pheromone matrix RTL.
// Both macros expect i_clk and i_rst_n in scope.
`ifndef PHEROMONE_MATRIX_UPDATE_CORE_ASSERT_SVH
`define PHEROMONE_MATRIX_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication.
`define PMU_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pheromone matrix: same-cycle check failed");

// Next-cycle implication.
`define PMU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pheromone matrix: next-cycle check failed");

`endif

// ----- rtl/core/pmu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared types and constants for the pheromone matrix update core.
// ----------------------------------------------------------------------------
package pmu_pkg;

    localparam int NODES   = 64;
    localparam int DEPTH   = NODES * NODES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam int CMD_W   = 2;
    localparam int NODE_W  = 6;
    localparam int LEN_W   = 24;
    localparam int AMT_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int LEVEL_W = 32;

    // from_node, to_node, path_length; padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_W     = 32;
    localparam int REM_W     = LEN_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [CMD_W-1:0] CMD_DEPOSIT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVAPORATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEPOSIT_AMOUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETAIN_FACTOR  = 8'd1;

    localparam logic [AMT_W-1:0]  DEPOSIT_AMOUNT_RST = 16'd1;
    localparam logic [FRAC_W-1:0] RETAIN_FACTOR_RST  = 16'd58982;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_DEP_RD,
        S_DEP_WR,
        S_RD,
        S_EVAP,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- rtl/core/pmu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmu_div
// Restoring divider, one quotient bit per cycle, 32-bit by 24-bit unsigned.
// ----------------------------------------------------------------------------
module pmu_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pmu_pkg::t_div_req i_req,
    output pmu_pkg::t_div_rsp o_rsp
);
    import pmu_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [LEN_W-1:0]     r_den;

    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] diff;
    logic             q_bit;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign q_bit = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], q_bit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- rtl/core/pheromone_matrix_update_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_matrix_update_core
// Pheromone level matrix for ant colony optimisation, Q16.16 entries held
// in one synchronous RAM with deposit, evaporate and read requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result. After reset
// the core runs a clearing pass over all NODES*NODES entries with tready
// low. A deposit runs the bit-serial divider, which forms
// deposit_amount*65536/path_length (32 steps), then a RAM read and
// write-back. An evaporate streams every entry through the RAM read port,
// a 32x16 multiplier and the write port. Deposits with zero length, bad
// nodes and unused commands go straight to the response state. A finished
// result waits in the output register while the next request is taken.
`include "pheromone_matrix_update_core_assert.svh"

module pheromone_matrix_update_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [5:0] from_node, [11:6] to_node, [35:12] path_length
    input  logic [pmu_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] command
    input  logic [pmu_pkg::CMD_W-1:0]         i_s_axis_tuser,
    // result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [31:0] level
    output logic [pmu_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // [0] error
    output logic                              o_m_axis_tuser,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pmu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pmu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pmu_pkg::*;

    t_state r_state, n_state;

    logic [AMT_W-1:0]   r_deposit_amount;
    logic [FRAC_W-1:0]  r_retain_factor;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_addr;
    logic [LEVEL_W-1:0] r_res_level;
    logic               r_res_err;

    logic               r_m_valid;
    logic [LEVEL_W-1:0] r_m_level;
    logic               r_m_err;

    // evaporate pipeline: read data stage, product stage
    logic               r_v1, r_v2;
    logic [ADDR_W-1:0]  r_a1, r_a2;
    logic [LEVEL_W-1:0] r_prod;

    logic [LEVEL_W-1:0] mem [DEPTH];
    logic [LEVEL_W-1:0] r_rd_data;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_wa, mem_ra;
    logic [LEVEL_W-1:0] mem_wd;

    logic [CMD_W-1:0]   in_cmd;
    logic [NODE_W-1:0]  in_from, in_to;
    logic [LEN_W-1:0]   in_len;
    logic               in_range;
    logic [ADDR_W-1:0]  in_addr;
    logic               accept;
    logic               out_free;
    logic               evap_issue;
    logic               evap_end;
    logic               clear_end;

    logic [LEVEL_W:0]          dep_sum;
    logic [LEVEL_W-1:0]        dep_sat;
    logic [LEVEL_W+FRAC_W-1:0] evap_prod;

    t_div_req div_req;
    t_div_rsp div_rsp;

    assign in_from  = i_s_axis_tdata[NODE_W-1:0];
    assign in_to    = i_s_axis_tdata[2*NODE_W-1:NODE_W];
    assign in_len   = i_s_axis_tdata[2*NODE_W+LEN_W-1:2*NODE_W];
    assign in_cmd   = i_s_axis_tuser;
    assign in_range = (32'(in_from) < 32'(NODES)) && (32'(in_to) < 32'(NODES));
    assign in_addr  = ADDR_W'(in_from) * ADDR_W'(NODES) + ADDR_W'(in_to);

    assign accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_m_valid || i_m_axis_tready;
    assign evap_issue = (r_cnt < CNT_W'(DEPTH));
    assign evap_end   = !evap_issue && !r_v1 && !r_v2;
    assign clear_end  = (r_cnt == CNT_W'(DEPTH - 1));

    assign dep_sum   = {1'b0, r_rd_data} + {1'b0, div_rsp.quotient};
    assign dep_sat   = dep_sum[LEVEL_W] ? '1 : dep_sum[LEVEL_W-1:0];
    assign evap_prod = r_rd_data * r_retain_factor;

    assign div_req.start    = accept && (in_cmd == CMD_DEPOSIT) && (in_len != '0) && in_range;
    assign div_req.dividend = {r_deposit_amount, {FRAC_W{1'b0}}};
    assign div_req.divisor  = in_len;

    pmu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (clear_end) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_DEPOSIT:   n_state = div_req.start ? S_DIV : S_RESP;
                        CMD_EVAPORATE: n_state = S_EVAP;
                        CMD_READ:      n_state = in_range ? S_RD : S_RESP;
                        default:       n_state = S_RESP;
                    endcase
                end
            end
            S_DIV:    if (div_rsp.done) n_state = S_DEP_RD;
            S_DEP_RD: n_state = S_DEP_WR;
            S_DEP_WR: n_state = S_RESP;
            S_RD:     n_state = S_RESP;
            S_EVAP:   if (evap_end) n_state = S_RESP;
            S_RESP:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // state outputs: handshake and RAM port controls
    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = dep_sat;
        mem_re = 1'b0;
        mem_ra = r_addr;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt[ADDR_W-1:0];
                mem_wd = '0;
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                mem_re = accept;
                mem_ra = in_addr;
            end
            S_DEP_RD: mem_re = 1'b1;
            S_DEP_WR: mem_we = 1'b1;
            S_EVAP: begin
                mem_re = evap_issue;
                mem_ra = r_cnt[ADDR_W-1:0];
                mem_we = r_v2;
                mem_wa = r_a2;
                mem_wd = r_prod;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd_data <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_cnt            <= '0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_m_valid        <= 1'b0;
            r_deposit_amount <= DEPOSIT_AMOUNT_RST;
            r_retain_factor  <= RETAIN_FACTOR_RST;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_EVAP) && evap_issue;
            r_v2    <= r_v1;

            if (r_state == S_CLEAR) begin
                r_cnt <= clear_end ? '0 : r_cnt + 1'b1;
            end else if (accept) begin
                r_cnt <= '0;
            end else if ((r_state == S_EVAP) && evap_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if ((r_state == S_RESP) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_DEPOSIT_AMOUNT) begin
                    r_deposit_amount <= i_cfg_data;
                end else if (i_cfg_index == REG_RETAIN_FACTOR) begin
                    r_retain_factor <= i_cfg_data;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_a1   <= r_cnt[ADDR_W-1:0];
        r_a2   <= r_a1;
        r_prod <= evap_prod[LEVEL_W+FRAC_W-1:FRAC_W];

        if (accept) begin
            r_addr      <= in_addr;
            r_res_level <= '0;
            r_res_err   <= (in_cmd == CMD_DEPOSIT) && (in_len == '0);
        end else if (r_state == S_DEP_WR) begin
            r_res_level <= dep_sat;
        end else if (r_state == S_RD) begin
            r_res_level <= r_rd_data;
        end

        if ((r_state == S_RESP) && out_free) begin
            r_m_level <= r_res_level;
            r_m_err   <= r_res_err;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_level;
    assign o_m_axis_tuser  = r_m_err;

    `PMU_ASSERT_IMPLY(a_no_req_in_clear, r_state == S_CLEAR, !o_s_axis_tready)
    `PMU_ASSERT_NEXT(a_one_at_a_time, accept, !o_s_axis_tready)
    `PMU_ASSERT_IMPLY(a_div_done_in_div, div_rsp.done, r_state == S_DIV)
    `PMU_ASSERT_IMPLY(a_evap_wr_only_evap, r_v2, r_state == S_EVAP)

endmodule

// ----- tb/pheromone_matrix_update_core_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_matrix_update_core_checker
// Watches the request, result and register channels of the pheromone matrix
// core, keeps its own copy of the matrix and weights, predicts each result
// and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module pheromone_matrix_update_core_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [pmu_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [pmu_pkg::CMD_W-1:0]      i_s_axis_tuser,
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [pmu_pkg::M_TDATA_W-1:0]  i_m_axis_tdata,
    input  logic                           i_m_axis_tuser,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pmu_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pmu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import pmu_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               error;
    } t_pher_result;

    logic [LEVEL_W-1:0] level_matrix [0:DEPTH-1];
    logic [AMT_W-1:0]   deposit_amount;
    logic [FRAC_W-1:0]  retain_factor;
    t_pher_result       awaited_levels [$];
    t_pher_result       want;
    int                 fails = 0;
    int                 checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Applies one request to the local matrix and returns the result it gives.
    function automatic t_pher_result update_matrix(
        input logic [CMD_W-1:0]  cmd,
        input logic [NODE_W-1:0] row,
        input logic [NODE_W-1:0] col,
        input logic [LEN_W-1:0]  len
    );
        t_pher_result       res;
        int                 addr;
        logic [DIV_W-1:0]   trace;
        logic [LEVEL_W:0]   sum;
        logic [47:0]        scaled;
        res = '0;
        addr = int'(row) * NODES + int'(col);
        case (cmd)
            CMD_DEPOSIT: begin
                if (len == '0) begin
                    res.error = 1'b1;
                end else if (row < NODES && col < NODES) begin
                    trace = {deposit_amount, 16'h0000} / DIV_W'(len);
                    sum = {1'b0, level_matrix[addr]} + {1'b0, trace};
                    if (sum[LEVEL_W])
                        sum = {1'b0, {LEVEL_W{1'b1}}};
                    level_matrix[addr] = sum[LEVEL_W-1:0];
                    res.level = sum[LEVEL_W-1:0];
                end
            end
            CMD_EVAPORATE: begin
                for (int k = 0; k < DEPTH; k++) begin
                    scaled = 48'(level_matrix[k]) * 48'(retain_factor);
                    level_matrix[k] = scaled[47:16];
                end
            end
            CMD_READ: begin
                if (row < NODES && col < NODES)
                    res.level = level_matrix[addr];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++)
                level_matrix[k] = '0;
            deposit_amount = DEPOSIT_AMOUNT_RST;
            retain_factor  = RETAIN_FACTOR_RST;
            awaited_levels.delete();
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (awaited_levels.size() == 0) begin
                    $display("%0t: result with none awaited, level %08h error %0b",
                             $time, i_m_axis_tdata, i_m_axis_tuser);
                    fails++;
                end else begin
                    want = awaited_levels.pop_front();
                    checked++;
                    if (i_m_axis_tdata !== want.level) begin
                        $display("%0t: level mismatch, expected %08h, actual %08h",
                                 $time, want.level, i_m_axis_tdata);
                        fails++;
                    end
                    if (i_m_axis_tuser !== want.error) begin
                        $display("%0t: error flag mismatch, expected %0b, actual %0b",
                                 $time, want.error, i_m_axis_tuser);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEPOSIT_AMOUNT: deposit_amount = i_cfg_data;
                    REG_RETAIN_FACTOR:  retain_factor  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                awaited_levels.push_back(update_matrix(i_s_axis_tuser,
                                                       i_s_axis_tdata[5:0],
                                                       i_s_axis_tdata[11:6],
                                                       i_s_axis_tdata[35:12]));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_levels.size();
        o_checked    <= checked;
    end

endmodule

// ----- tb/pheromone_matrix_update_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pheromone_matrix_update_core_test
// Drives deposit, evaporate, read and unused requests into the pheromone
// matrix core under several weight settings and handshake idling patterns;
// the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module pheromone_matrix_update_core_test;
    import pmu_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;
    localparam logic [NODE_W-1:0]    NODE_MAX     = NODE_W'(NODES - 1);
    localparam logic [LEN_W-1:0]     LEN_MAX      = {LEN_W{1'b1}};
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 188;
    localparam int HOLD_CYCLES = 400;
    // clearing pass or one evaporate plus stalls, with margin
    localparam int STALL_LIMIT = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int checked;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int n_deposit = 0;
    int n_zero_len = 0;
    int n_evaporate = 0;
    int n_read = 0;
    int n_unused = 0;
    int n_settings = 0;

    pheromone_matrix_update_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    pheromone_matrix_update_core_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Result side: random back-pressure, or a long hold-off when asked.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(
        input logic [CMD_W-1:0]  cmd,
        input logic [NODE_W-1:0] row,
        input logic [NODE_W-1:0] col,
        input logic [LEN_W-1:0]  len
    );
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'h0, len, col, row};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        case (cmd)
            CMD_DEPOSIT: begin
                n_deposit++;
                if (len == '0)
                    n_zero_len++;
            end
            CMD_EVAPORATE: n_evaporate++;
            CMD_READ:      n_read++;
            default:       n_unused++;
        endcase
    endtask

    // Sender pauses until every outstanding result has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Only called with the core idle; the unmapped write must be ignored.
    task automatic set_weights(input logic [AMT_W-1:0] amount,
                               input logic [FRAC_W-1:0] retain);
        write_reg(REG_DEPOSIT_AMOUNT, amount);
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        write_reg(REG_RETAIN_FACTOR, retain);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Most traffic lands on a few corner nodes so entries build up and saturate.
    function automatic logic [NODE_W-1:0] pick_node();
        int n;
        if ($urandom_range(0, 99) < 30)
            return NODE_W'($urandom);
        n = $urandom_range(0, 3);
        return (n < 2) ? NODE_W'(n) : NODE_W'(NODES - 4 + n);
    endfunction

    task automatic send_random();
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] row;
        logic [NODE_W-1:0] col;
        logic [LEN_W-1:0]  len;
        int                roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            cmd = CMD_EVAPORATE;
        else if (roll < 8)
            cmd = CMD_UNUSED;
        else if (roll < 58)
            cmd = CMD_DEPOSIT;
        else
            cmd = CMD_READ;
        row = pick_node();
        col = pick_node();
        roll = $urandom_range(0, 99);
        if (roll < 6)
            len = '0;
        else if (roll < 46)
            len = LEN_W'($urandom_range(1, 8));
        else if (roll < 56)
            len = LEN_MAX;
        else
            len = LEN_W'($urandom);
        send_request(cmd, row, col, len);
    endtask

    // Receiver stalls for a long stretch while reads keep coming, filling the core.
    task automatic hold_off();
        int saved_pct;
        saved_pct = tx_idle_pct;
        tx_idle_pct = 0;
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++)
            send_request(CMD_READ, pick_node(), pick_node(), LEN_W'($urandom));
        tx_idle_pct = saved_pct;
    endtask

    initial begin
        logic [AMT_W-1:0]  amount;
        logic [FRAC_W-1:0] retain;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // weights at reset values; matrix starts cleared
        send_request(CMD_READ, '0, '0, '0);
        send_request(CMD_READ, NODE_MAX, NODE_MAX, LEN_MAX);
        send_request(CMD_DEPOSIT, '0, '0, LEN_W'(1));
        send_request(CMD_DEPOSIT, NODE_MAX, NODE_MAX, LEN_MAX);
        send_request(CMD_DEPOSIT, '0, NODE_MAX, '0);
        send_request(CMD_DEPOSIT, NODE_MAX, '0, LEN_W'(3));
        send_request(CMD_READ, '0, '0, '0);
        send_request(CMD_EVAPORATE, '0, '0, '0);
        send_request(CMD_READ, '0, '0, '0);
        send_request(CMD_READ, NODE_MAX, '0, '0);
        send_request(CMD_UNUSED, NODE_MAX, NODE_MAX, LEN_MAX);

        // largest budget and the highest retain factor: saturation
        drain();
        set_weights('1, '1);
        send_request(CMD_DEPOSIT, NODE_W'(5), NODE_W'(9), LEN_W'(1));
        send_request(CMD_DEPOSIT, NODE_W'(5), NODE_W'(9), LEN_W'(1));
        send_request(CMD_DEPOSIT, NODE_W'(5), NODE_W'(9), LEN_W'(1));
        send_request(CMD_READ, NODE_W'(5), NODE_W'(9), '0);
        send_request(CMD_EVAPORATE, NODE_MAX, NODE_MAX, LEN_MAX);
        send_request(CMD_READ, NODE_W'(5), NODE_W'(9), '0);

        // zero budget and full evaporation
        drain();
        set_weights('0, '0);
        send_request(CMD_DEPOSIT, NODE_W'(5), NODE_W'(9), LEN_W'(1));
        send_request(CMD_EVAPORATE, '0, '0, '0);
        send_request(CMD_READ, NODE_W'(5), NODE_W'(9), '0);
        send_request(CMD_READ, '0, '0, '0);
        send_request(CMD_DEPOSIT, NODE_W'(5), NODE_W'(9), '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0:       begin amount = '1;            retain = '1;            end
                2:       begin amount = AMT_W'(40000); retain = FRAC_W'(32768); end
                3:       begin amount = '0;            retain = '1;            end
                5:       begin amount = '1;            retain = FRAC_W'(1);    end
                default: begin amount = AMT_W'($urandom); retain = FRAC_W'($urandom); end
            endcase
            set_weights(amount, retain);
            if (ph < 2) begin
                tx_idle_pct = 30;
                rx_idle_pct = 48;
            end else if (ph < 4) begin
                tx_idle_pct = 48;
                rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain();
                if (ph == 2 && n == PHASE_ITEMS / 2)
                    hold_off();
                send_random();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        $display("Sent %0d requests: %0d deposits (%0d zero length), %0d evaporates, %0d reads, %0d unused",
                 n_deposit + n_evaporate + n_read + n_unused, n_deposit, n_zero_len,
                 n_evaporate, n_read, n_unused);
        $display("%0d results compared across %0d weight settings plus reset values",
                 checked, n_settings);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
